// ===== rtl/core/vgs_pkg.sv =====
`timescale 1ns / 1ps

package vgs_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_REG_BYTES   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_COUNT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCAN_PERIOD = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_MAP_N  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEG_MAP_N   = 3'd4;

   // register reset values
   localparam logic [3:0]  RST_REG_BYTES   = 4'd4;
   localparam logic [4:0]  RST_GRID_COUNT  = 5'd10;
   localparam logic [15:0] RST_SCAN_PERIOD = 16'd333;
   localparam logic [4:0]  RST_GRID_MAP_N  = 5'd17;
   localparam logic [6:0]  RST_SEG_MAP_N   = 7'd64;

   // request codes
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_SEG_WR   = 3'd1;
   localparam logic [2:0] REQ_CLEAR    = 3'd2;
   localparam logic [2:0] REQ_ALL_ON   = 3'd3;
   localparam logic [2:0] REQ_LD_GRID  = 3'd4;
   localparam logic [2:0] REQ_LD_SEG   = 3'd5;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_SCAN   = 1'b1;

   localparam logic [7:0] FILL_OFF = 8'h00;
   localparam logic [7:0] FILL_ON  = 8'hFF;

   typedef struct packed {
      logic [2:0] req_type;
      logic [4:0] grid_pin;
      logic [5:0] seg_pin;
      logic       seg_on;
      logic [5:0] map_bit;
   } req_item_type;

   typedef struct packed {
      logic       kind;
      logic       ok;
      logic [7:0] data_byte;
      logic       strobe_res;
      logic [3:0] grid_now;
      logic       last;
   } rsp_item_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [3:0]  nb;
      logic [6:0]  grids;
      logic [15:0] period;
      logic [6:0]  gme;
      logic [6:0]  sme;
   } cfg_eff_type;

endpackage

// ===== rtl/core/vfd_grid_scan_controller.sv =====
`timescale 1ns / 1ps

// Scan controller for a multiplexed VFD. A frame store keeps one driver-chain
// image per grid; request items load the grid and segment pin maps, light or
// darken a segment, clear the display or light every pin, and each gets one
// status item back. Tick items count toward scan_period; the tick that reaches
// it sends out the current grid's reg_bytes bytes, the first one flagged for
// the blank/latch/unblank strobe, and moves on to the next grid. Items are taken
// one at a time; the frame store has one registered read port. A tick that
// does not scan leaves the block idle; a scanning tick runs TICK and SCAN, a
// segment write SEG_MAP, PUT and REPLY (only REPLY if rejected, no PUT if its
// bit lies beyond the chain), a map load or all-on REPLY, and a clear CLR, a
// CLR and PUT per grid in use (no PUT for a bit beyond the chain), then REPLY.
// SCAN and REPLY wait while the result side is not taking items. No clearing
// pass follows reset: the block takes items from the first cycle after reset.
module vfd_grid_scan_controller import vgs_pkg::*; #(
   parameter int MAX_GRIDS       = 16,
   parameter int MAX_REG_BYTES   = 8,
   parameter int MAX_SEG_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // grid_pin[4:0], seg_pin[10:5], seg_on[11], map_bit[17:12], zero[23:18]
   input  logic [23:0]           req_tdata,
   // req_type[2:0]
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ok[0], data_byte[8:1], strobe_res[9], grid_now[13:10], zero[15:14]
   output logic [15:0]           rsp_tdata,
   // kind[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_eff_type  cfg;
   req_item_type req_item;
   rsp_item_type rsp_next;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free;
   logic         emit;

   assign req_item.req_type = req_tuser;
   assign req_item.grid_pin = req_tdata[4:0];
   assign req_item.seg_pin  = req_tdata[10:5];
   assign req_item.seg_on   = req_tdata[11];
   assign req_item.map_bit  = req_tdata[17:12];

   vgs_cfg #(
      .MAX_GRIDS       (MAX_GRIDS),
      .MAX_REG_BYTES   (MAX_REG_BYTES),
      .MAX_SEG_ENTRIES (MAX_SEG_ENTRIES)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   vgs_seq #(
      .MAX_GRIDS       (MAX_GRIDS),
      .MAX_REG_BYTES   (MAX_REG_BYTES),
      .MAX_SEG_ENTRIES (MAX_SEG_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .cfg       (cfg),
      .out_free  (out_free),
      .emit      (emit),
      .rsp_item  (rsp_next)
   );

   // output register: a new item loads when the slot is empty or being taken
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = rsp_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.grid_now, rsp_item_ff.strobe_res,
                        rsp_item_ff.data_byte, rsp_item_ff.ok};
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tlast  = rsp_item_ff.last;

   // any request other than a tick makes the block busy right after it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != REQ_TICK)) |=> !req_tready)
      else $error("block took a new item right after a request");

   // when idle, anything still waiting on the result side closes its item
   a_idle_holds_last: assert property (@(posedge clock) disable iff (reset)
      (req_tready && rsp_tvalid) |-> rsp_tlast)
      else $error("block idle while an item's results are incomplete");

   // a scanned byte always reports ok, a status item never carries a strobe
   a_scan_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_STATUS) ? !rsp_tdata[9] : rsp_tdata[0]))
      else $error("scanned byte without ok or status item flagged with strobe");

endmodule

// ===== rtl/core/vgs_ram.sv =====
`timescale 1ns / 1ps

module vgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vgs_cfg.sv =====
`timescale 1ns / 1ps

module vgs_cfg import vgs_pkg::*; #(
   parameter int MAX_GRIDS       = 16,
   parameter int MAX_REG_BYTES   = 8,
   parameter int MAX_SEG_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_eff_type           cfg
);

   logic [3:0]  reg_bytes_ff,   reg_bytes_in;
   logic [4:0]  grid_count_ff,  grid_count_in;
   logic [15:0] scan_period_ff, scan_period_in;
   logic [4:0]  grid_map_n_ff,  grid_map_n_in;
   logic [6:0]  seg_map_n_ff,   seg_map_n_in;

   always_comb begin
      reg_bytes_in   = reg_bytes_ff;
      grid_count_in  = grid_count_ff;
      scan_period_in = scan_period_ff;
      grid_map_n_in  = grid_map_n_ff;
      seg_map_n_in   = seg_map_n_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_REG_BYTES:   reg_bytes_in   = csr_wr_data[3:0];
            CSR_GRID_COUNT:  grid_count_in  = csr_wr_data[4:0];
            CSR_SCAN_PERIOD: scan_period_in = csr_wr_data[15:0];
            CSR_GRID_MAP_N:  grid_map_n_in  = csr_wr_data[4:0];
            CSR_SEG_MAP_N:   seg_map_n_in   = csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_bytes_ff   <= RST_REG_BYTES;
         grid_count_ff  <= RST_GRID_COUNT;
         scan_period_ff <= RST_SCAN_PERIOD;
         grid_map_n_ff  <= RST_GRID_MAP_N;
         seg_map_n_ff   <= RST_SEG_MAP_N;
      end else begin
         reg_bytes_ff   <= reg_bytes_in;
         grid_count_ff  <= grid_count_in;
         scan_period_ff <= scan_period_in;
         grid_map_n_ff  <= grid_map_n_in;
         seg_map_n_ff   <= seg_map_n_in;
      end
   end

   // out-of-range settings fold onto the nearest legal value
   always_comb begin
      if (reg_bytes_ff == 4'd0) begin
         cfg.nb = 4'd1;
      end else if (7'(reg_bytes_ff) > 7'(MAX_REG_BYTES)) begin
         cfg.nb = 4'(MAX_REG_BYTES);
      end else begin
         cfg.nb = reg_bytes_ff;
      end

      if (grid_count_ff == 5'd0) begin
         cfg.grids = 7'd1;
      end else if (7'(grid_count_ff) > 7'(MAX_GRIDS)) begin
         cfg.grids = 7'(MAX_GRIDS);
      end else begin
         cfg.grids = 7'(grid_count_ff);
      end

      cfg.period = (scan_period_ff == 16'd0) ? 16'd1 : scan_period_ff;

      cfg.gme = (7'(grid_map_n_ff) > 7'(MAX_GRIDS + 1)) ? 7'(MAX_GRIDS + 1)
                                                         : 7'(grid_map_n_ff);
      cfg.sme = (seg_map_n_ff > 7'(MAX_SEG_ENTRIES)) ? 7'(MAX_SEG_ENTRIES) : seg_map_n_ff;
   end

endmodule

// ===== rtl/core/vgs_seq.sv =====
`timescale 1ns / 1ps

module vgs_seq import vgs_pkg::*; #(
   parameter int MAX_GRIDS       = 16,
   parameter int MAX_REG_BYTES   = 8,
   parameter int MAX_SEG_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  cfg_eff_type  cfg,
   input  logic         out_free,
   output logic         emit,
   output rsp_item_type rsp_item
);

   localparam int GRID_ENTRIES = MAX_GRIDS + 1;
   localparam int STORE_BYTES  = MAX_GRIDS * MAX_REG_BYTES;
   localparam int SA_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int MA_W  = (MAX_SEG_ENTRIES > 1) ? $clog2(MAX_SEG_ENTRIES) : 1;
   localparam int GM_W  = $clog2(GRID_ENTRIES);
   localparam int ROW_W = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;
   localparam int GC_W  = $clog2(MAX_GRIDS + 2);
   localparam int K_W   = (MAX_REG_BYTES > 1) ? $clog2(MAX_REG_BYTES) : 1;
   localparam int MW    = SA_W + 4;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_TICK    = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_SEG_MAP = 7'b0001000,
      ST_CLR     = 7'b0010000,
      ST_PUT     = 7'b0100000,
      ST_REPLY   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [15:0]             tick_ff, tick_in;
   logic [ROW_W-1:0]        cur_ff, cur_in;
   logic [SA_W-1:0]         base_ff, base_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [GC_W-1:0]         g_ff, g_in;
   logic [4:0]              gp_ff, gp_in;
   logic                    on_ff, on_in;
   logic                    clr_ff, clr_in;
   logic                    ok_ff, ok_in;
   logic [SA_W-1:0]         put_idx_ff, put_idx_in;
   logic [7:0]              put_mask_ff, put_mask_in;
   logic [7:0]              fill_ff, fill_in;
   logic [STORE_BYTES-1:0]  store_vld_ff, store_vld_in;
   logic                    store_rv_ff, store_rv_in;
   logic [MAX_SEG_ENTRIES-1:0] seg_vld_ff, seg_vld_in;
   logic                    seg_rv_ff, seg_rv_in;
   logic [5:0]              grid_map_ff [GRID_ENTRIES];
   logic [5:0]              grid_map_in [GRID_ENTRIES];

   // frame store port
   logic            st_rd_en, st_we;
   logic [SA_W-1:0] st_rd_addr;
   logic [7:0]      st_q, st_wdata;
   // segment map port
   logic            sm_rd_en, sm_we;
   logic [MA_W-1:0] sm_rd_addr, sm_wr_addr;
   logic [5:0]      sm_q;

   logic [7:0]       store_byte;
   logic [5:0]       seg_bit;
   logic [ROW_W-1:0] put_row;
   logic [5:0]       put_bit;
   logic [2:0]       put_off;
   logic             put_in_chain;
   logic [MW-1:0]    put_idx_w;
   logic [SA_W-1:0]  put_idx;
   logic [15:0]      tick_inc;
   logic [ROW_W-1:0] cur_eff;
   logic [MW-1:0]    base_w;
   logic [MW-1:0]    scan_next_w;
   logic             last_byte;
   logic             seg_reject;

   vgs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (put_idx_ff),
      .wr_data (st_wdata),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_q)
   );

   vgs_ram #(.WIDTH(6), .DEPTH(MAX_SEG_ENTRIES)) u_seg_map (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_wr_addr),
      .wr_data (req_item.map_bit),
      .rd_en   (sm_rd_en),
      .rd_addr (sm_rd_addr),
      .rd_data (sm_q)
   );

   // entries not written since the last reset, clear or all-on read as the fill value
   assign store_byte = store_rv_ff ? st_q : fill_ff;
   assign seg_bit    = seg_rv_ff ? sm_q : 6'd0;

   // shared read-modify-write address path for segment writes and clear
   always_comb begin
      if (state_ff == ST_CLR) begin
         put_row = ROW_W'(g_ff - GC_W'(1));
         put_bit = grid_map_ff[GM_W'(g_ff)];
      end else begin
         put_row = ROW_W'(gp_ff - 5'd1);
         put_bit = seg_bit;
      end
   end

   assign put_off      = put_bit[5:3];
   assign put_in_chain = {1'b0, put_off} < cfg.nb;
   // high byte of the row sits at the lowest address
   assign put_idx_w    = MW'(put_row) * MW'(cfg.nb) + MW'(cfg.nb) - MW'(1) - MW'(put_off);
   assign put_idx      = put_idx_w[SA_W-1:0];

   assign tick_inc    = tick_ff + 16'd1;
   assign cur_eff     = (7'(cur_ff) >= cfg.grids) ? '0 : cur_ff;
   assign base_w      = MW'(cur_eff) * MW'(cfg.nb);
   assign scan_next_w = MW'(base_ff) + MW'(k_ff) + MW'(1);
   assign last_byte   = (4'(k_ff) + 4'd1) == cfg.nb;

   assign seg_reject = (req_item.grid_pin == 5'd0)
                    || (7'(req_item.grid_pin) >= cfg.gme)
                    || (7'(req_item.grid_pin) > cfg.grids)
                    || (7'(req_item.seg_pin) >= cfg.sme);

   assign req_ready  = (state_ff == ST_IDLE);
   assign sm_rd_addr = MA_W'(req_item.seg_pin);
   assign sm_wr_addr = MA_W'(req_item.seg_pin);

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      gp_in        = gp_ff;
      on_in        = on_ff;
      clr_in       = clr_ff;
      ok_in        = ok_ff;
      put_idx_in   = put_idx_ff;
      put_mask_in  = put_mask_ff;
      fill_in      = fill_ff;
      store_vld_in = store_vld_ff;
      store_rv_in  = store_rv_ff;
      seg_vld_in   = seg_vld_ff;
      seg_rv_in    = seg_rv_ff;
      grid_map_in  = grid_map_ff;

      st_rd_en   = 1'b0;
      st_rd_addr = put_idx;
      st_we      = 1'b0;
      st_wdata   = on_ff ? (store_byte | put_mask_ff) : (store_byte & ~put_mask_ff);
      sm_rd_en   = 1'b0;
      sm_we      = 1'b0;

      emit               = 1'b0;
      rsp_item.kind       = KIND_STATUS;
      rsp_item.ok         = ok_ff;
      rsp_item.data_byte  = 8'd0;
      rsp_item.strobe_res = 1'b0;
      rsp_item.grid_now   = 4'd0;
      rsp_item.last       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               gp_in  = req_item.grid_pin;
               on_in  = req_item.seg_on;
               clr_in = 1'b0;
               ok_in  = 1'b1;
               state_in = ST_REPLY;
               case (req_item.req_type)
                  REQ_TICK: begin
                     if (tick_inc >= cfg.period) begin
                        tick_in  = 16'd0;
                        state_in = ST_TICK;
                     end else begin
                        tick_in  = tick_inc;
                        state_in = ST_IDLE;
                     end
                  end
                  REQ_SEG_WR: begin
                     if (seg_reject) begin
                        ok_in = 1'b0;
                     end else begin
                        sm_rd_en  = 1'b1;
                        seg_rv_in = seg_vld_ff[sm_rd_addr];
                        state_in  = ST_SEG_MAP;
                     end
                  end
                  REQ_CLEAR: begin
                     store_vld_in = '0;
                     fill_in      = FILL_OFF;
                     g_in         = GC_W'(1);
                     on_in        = 1'b1;
                     clr_in       = 1'b1;
                     state_in     = ST_CLR;
                  end
                  REQ_ALL_ON: begin
                     store_vld_in = '0;
                     fill_in      = FILL_ON;
                  end
                  REQ_LD_GRID: begin
                     if (7'(req_item.grid_pin) < 7'(GRID_ENTRIES)) begin
                        grid_map_in[GM_W'(req_item.grid_pin)] = req_item.map_bit;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  REQ_LD_SEG: begin
                     if (7'(req_item.seg_pin) < 7'(MAX_SEG_ENTRIES)) begin
                        sm_we                  = 1'b1;
                        seg_vld_in[sm_wr_addr] = 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  default: ok_in = 1'b0;
               endcase
            end
         end

         ST_TICK: begin
            cur_in      = cur_eff;
            base_in     = base_w[SA_W-1:0];
            k_in        = '0;
            st_rd_en    = 1'b1;
            st_rd_addr  = base_w[SA_W-1:0];
            store_rv_in = store_vld_ff[st_rd_addr];
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            rsp_item.kind       = KIND_SCAN;
            rsp_item.ok         = 1'b1;
            rsp_item.data_byte  = store_byte;
            rsp_item.strobe_res = (k_ff == '0);
            rsp_item.grid_now   = 4'(cur_ff);
            rsp_item.last       = last_byte;
            if (out_free) begin
               emit = 1'b1;
               if (last_byte) begin
                  cur_in   = ((7'(cur_ff) + 7'd1) >= cfg.grids) ? '0 : ROW_W'(cur_ff + 1'b1);
                  state_in = ST_IDLE;
               end else begin
                  k_in        = k_ff + 1'b1;
                  st_rd_en    = 1'b1;
                  st_rd_addr  = scan_next_w[SA_W-1:0];
                  store_rv_in = store_vld_ff[st_rd_addr];
               end
            end
         end

         ST_SEG_MAP: begin
            if (put_in_chain) begin
               st_rd_en    = 1'b1;
               store_rv_in = store_vld_ff[st_rd_addr];
               put_idx_in  = put_idx;
               put_mask_in = 8'd1 << put_bit[2:0];
               state_in    = ST_PUT;
            end else begin
               state_in = ST_REPLY;
            end
         end

         ST_CLR: begin
            if (7'(g_ff) > cfg.grids) begin
               state_in = ST_REPLY;
            end else if (put_in_chain) begin
               st_rd_en    = 1'b1;
               store_rv_in = store_vld_ff[st_rd_addr];
               put_idx_in  = put_idx;
               put_mask_in = 8'd1 << put_bit[2:0];
               state_in    = ST_PUT;
            end else begin
               g_in = g_ff + 1'b1;
            end
         end

         ST_PUT: begin
            st_we                    = 1'b1;
            store_vld_in[put_idx_ff] = 1'b1;
            if (clr_ff) begin
               g_in     = g_ff + 1'b1;
               state_in = ST_CLR;
            end else begin
               state_in = ST_REPLY;
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= 16'd0;
         cur_ff       <= '0;
         fill_ff      <= FILL_OFF;
         store_vld_ff <= '0;
         seg_vld_ff   <= '0;
         for (int i = 0; i < GRID_ENTRIES; i++) begin
            grid_map_ff[i] <= 6'd0;
         end
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         cur_ff       <= cur_in;
         fill_ff      <= fill_in;
         store_vld_ff <= store_vld_in;
         seg_vld_ff   <= seg_vld_in;
         grid_map_ff  <= grid_map_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      k_ff        <= k_in;
      g_ff        <= g_in;
      gp_ff       <= gp_in;
      on_ff       <= on_in;
      clr_ff      <= clr_in;
      ok_ff       <= ok_in;
      put_idx_ff  <= put_idx_in;
      put_mask_ff <= put_mask_in;
      store_rv_ff <= store_rv_in;
      seg_rv_ff   <= seg_rv_in;
   end

endmodule

// ===== tb/vfd_scan_scoreboard.sv =====
`timescale 1ns / 1ps

module vfd_scan_scoreboard import vgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    results_pending
);

   localparam int GRID_LIMIT   = 16;
   localparam int BYTE_LIMIT   = 8;
   localparam int SEG_ENTRIES  = 64;
   localparam int GRID_ENTRIES = GRID_LIMIT + 1;
   localparam int STORE_BYTES  = GRID_LIMIT * BYTE_LIMIT;

   logic [7:0]  frame_mem [STORE_BYTES];
   logic [5:0]  grid_bit_of [GRID_ENTRIES];
   logic [5:0]  seg_bit_of [SEG_ENTRIES];
   int unsigned scan_grid;
   logic [15:0] tick_cnt;

   logic [3:0]  cfg_bytes;
   logic [4:0]  cfg_grids;
   logic [15:0] cfg_period;
   logic [4:0]  cfg_gme;
   logic [6:0]  cfg_sme;

   rsp_item_type rsp_items_due [$];

   function automatic int unsigned chain_bytes();
      if (cfg_bytes == 0) return 1;
      if (cfg_bytes > BYTE_LIMIT) return BYTE_LIMIT;
      return cfg_bytes;
   endfunction

   function automatic int unsigned active_grids();
      if (cfg_grids == 0) return 1;
      if (cfg_grids > GRID_LIMIT) return GRID_LIMIT;
      return cfg_grids;
   endfunction

   // driver bits go out first-shifted: high byte sits at the lowest address
   function automatic void set_driver_bit(int unsigned row, logic [5:0] bit_pos, logic on);
      int unsigned nb;
      int unsigned byte_off;
      int unsigned idx;
      nb = chain_bytes();
      byte_off = bit_pos[5:3];
      if (byte_off >= nb || row >= GRID_LIMIT) return;
      idx = row * nb + (nb - 1 - byte_off);
      frame_mem[idx][bit_pos[2:0]] = on;
   endfunction

   function automatic void push_status(logic ok);
      rsp_item_type item;
      item.kind       = KIND_STATUS;
      item.ok         = ok;
      item.data_byte  = FILL_OFF;
      item.strobe_res = 1'b0;
      item.grid_now   = 4'd0;
      item.last       = 1'b1;
      rsp_items_due.push_back(item);
   endfunction

   function automatic void apply_request(logic [2:0] op, logic [23:0] d);
      logic [4:0]   gp;
      logic [5:0]   sp;
      logic         on;
      logic [5:0]   mb;
      int unsigned  period;
      int unsigned  nb;
      int unsigned  grids;
      int unsigned  gme;
      int unsigned  sme;
      rsp_item_type item;
      gp = d[4:0];
      sp = d[10:5];
      on = d[11];
      mb = d[17:12];
      case (op)
         REQ_TICK: begin
            period = (cfg_period == 0) ? 1 : cfg_period;
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= period) begin
               tick_cnt = 16'd0;
               nb = chain_bytes();
               grids = active_grids();
               // grid count may have shrunk under the scan position
               if (scan_grid >= grids) scan_grid = 0;
               for (int k = 0; k < nb; k++) begin
                  item.kind       = KIND_SCAN;
                  item.ok         = 1'b1;
                  item.data_byte  = frame_mem[scan_grid * nb + k];
                  item.strobe_res = (k == 0);
                  item.grid_now   = scan_grid[3:0];
                  item.last       = (k == nb - 1);
                  rsp_items_due.push_back(item);
               end
               scan_grid = scan_grid + 1;
               if (scan_grid >= grids) scan_grid = 0;
            end
         end
         REQ_SEG_WR: begin
            gme = (cfg_gme > GRID_ENTRIES) ? GRID_ENTRIES : cfg_gme;
            sme = (cfg_sme > SEG_ENTRIES) ? SEG_ENTRIES : cfg_sme;
            if (gp == 0 || gp >= gme || gp > active_grids() || sp >= sme) begin
               push_status(1'b0);
            end else begin
               set_driver_bit(gp - 1, seg_bit_of[sp], on);
               push_status(1'b1);
            end
         end
         REQ_CLEAR: begin
            foreach (frame_mem[i]) frame_mem[i] = FILL_OFF;
            for (int g = 1; g <= active_grids() && g < GRID_ENTRIES; g++)
               set_driver_bit(g - 1, grid_bit_of[g], 1'b1);
            push_status(1'b1);
         end
         REQ_ALL_ON: begin
            foreach (frame_mem[i]) frame_mem[i] = FILL_ON;
            push_status(1'b1);
         end
         REQ_LD_GRID: begin
            if (gp >= GRID_ENTRIES) begin
               push_status(1'b0);
            end else begin
               grid_bit_of[gp] = mb;
               push_status(1'b1);
            end
         end
         REQ_LD_SEG: begin
            seg_bit_of[sp] = mb;
            push_status(1'b1);
         end
         default: push_status(1'b0);
      endcase
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         foreach (frame_mem[i]) frame_mem[i] = FILL_OFF;
         foreach (grid_bit_of[i]) grid_bit_of[i] = 6'd0;
         foreach (seg_bit_of[i]) seg_bit_of[i] = 6'd0;
         scan_grid  = 0;
         tick_cnt   = 16'd0;
         cfg_bytes  = RST_REG_BYTES;
         cfg_grids  = RST_GRID_COUNT;
         cfg_period = RST_SCAN_PERIOD;
         cfg_gme    = RST_GRID_MAP_N;
         cfg_sme    = RST_SEG_MAP_N;
         rsp_items_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_REG_BYTES:   cfg_bytes  = csr_wr_data[3:0];
               CSR_GRID_COUNT:  cfg_grids  = csr_wr_data[4:0];
               CSR_SCAN_PERIOD: cfg_period = csr_wr_data[15:0];
               CSR_GRID_MAP_N:  cfg_gme    = csr_wr_data[4:0];
               CSR_SEG_MAP_N:   cfg_sme    = csr_wr_data[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) apply_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_items_due.size() == 0) begin
               $error("result item with nothing expected: tuser %0d tdata 0x%0h tlast %0d",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = rsp_items_due.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("ok", want.ok, rsp_tdata[0]);
               check_field("data_byte", want.data_byte, rsp_tdata[8:1]);
               check_field("strobe_res", want.strobe_res, rsp_tdata[9]);
               check_field("grid_now", want.grid_now, rsp_tdata[13:10]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
      results_pending <= rsp_items_due.size();
   end

endmodule

// ===== tb/vfd_grid_scan_controller_test.sv =====
`timescale 1ns / 1ps

module vfd_grid_scan_controller_test;
   import vgs_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 40;

   // request codes the block does not know
   localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic [2:0]            req_tuser = REQ_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_REG_BYTES;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int mismatch_count;
   int results_pending;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   // register values as last written
   int unsigned set_bytes, set_grids, set_period, set_gme, set_sme;

   vfd_grid_scan_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   vfd_scan_scoreboard scan_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [23:0] pack_req(int unsigned gp, int unsigned sp,
                                            int unsigned on, int unsigned mb);
      return {6'd0, mb[5:0], on[0], sp[5:0], gp[4:0]};
   endfunction

   // valid stays high from one item to the next unless an idle gap is drawn
   task automatic send_item(input logic [2:0] op, input logic [23:0] d);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] a, input int unsigned v);
      csr_wr_en   <= 1'b1;
      csr_addr    <= a;
      csr_wr_data <= v[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic write_config(input int unsigned rb, input int unsigned gc,
                               input int unsigned sp, input int unsigned gme,
                               input int unsigned sme);
      write_reg(CSR_REG_BYTES, rb);
      write_reg(CSR_GRID_COUNT, gc);
      write_reg(CSR_SCAN_PERIOD, sp);
      write_reg(CSR_GRID_MAP_N, gme);
      write_reg(CSR_SEG_MAP_N, sme);
      csr_wr_en  <= 1'b0;
      set_bytes  = rb;
      set_grids  = gc;
      set_period = sp;
      set_gme    = gme;
      set_sme    = sme;
   endtask

   task automatic send_random();
      int unsigned r, gp, sp, on, mb;
      int unsigned nb, grids, gme, sme, top_gp;
      logic [2:0]  op;
      nb     = (set_bytes == 0) ? 1 : (set_bytes > 8) ? 8 : set_bytes;
      grids  = (set_grids == 0) ? 1 : (set_grids > 16) ? 16 : set_grids;
      gme    = (set_gme > 17) ? 17 : set_gme;
      sme    = (set_sme > 64) ? 64 : set_sme;
      top_gp = (gme == 0) ? 0 : ((gme - 1 < grids) ? gme - 1 : grids);
      r  = $urandom_range(99);
      gp = $urandom_range(31);
      sp = $urandom_range(63);
      on = $urandom_range(1);
      mb = $urandom_range(63);
      if (r < 45) begin
         op = REQ_TICK;
      end else if (r < 70) begin
         op = REQ_SEG_WR;
         if ($urandom_range(9) != 0 && top_gp >= 1 && sme >= 1) begin
            gp = $urandom_range(top_gp, 1);
            sp = $urandom_range(sme - 1, 0);
         end
      end else if (r < 80) begin
         op = REQ_LD_SEG;
         if ($urandom_range(3) != 0) mb = $urandom_range(nb * 8 - 1, 0);
      end else if (r < 88) begin
         op = REQ_LD_GRID;
         if ($urandom_range(5) != 0) gp = $urandom_range(16);
         if ($urandom_range(3) != 0) mb = $urandom_range(nb * 8 - 1, 0);
      end else if (r < 93) begin
         op = REQ_CLEAR;
      end else if (r < 96) begin
         op = REQ_ALL_ON;
      end else begin
         op = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      end
      send_item(op, pack_req(gp, sp, on, mb));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_bytes  = RST_REG_BYTES;
      set_grids  = RST_GRID_COUNT;
      set_period = RST_SCAN_PERIOD;
      set_gme    = RST_GRID_MAP_N;
      set_sme    = RST_SEG_MAP_N;

      // map loads at the index limits, in and out of range
      send_item(REQ_LD_GRID, pack_req(0, 0, 0, 63));
      send_item(REQ_LD_GRID, pack_req(1, 0, 0, 0));
      send_item(REQ_LD_GRID, pack_req(16, 0, 0, 31));
      send_item(REQ_LD_GRID, pack_req(17, 0, 0, 5));
      send_item(REQ_LD_GRID, pack_req(31, 0, 0, 0));
      send_item(REQ_LD_SEG, pack_req(0, 0, 0, 0));
      send_item(REQ_LD_SEG, pack_req(0, 63, 0, 63));
      send_item(REQ_LD_SEG, pack_req(0, 1, 0, 7));
      send_item(REQ_LD_SEG, pack_req(0, 2, 0, 31));
      // segment writes: grid zero, top grid, past grid count, bit beyond chain
      send_item(REQ_SEG_WR, pack_req(0, 1, 1, 0));
      send_item(REQ_SEG_WR, pack_req(10, 1, 1, 0));
      send_item(REQ_SEG_WR, pack_req(11, 1, 1, 0));
      send_item(REQ_SEG_WR, pack_req(1, 63, 1, 0));
      send_item(REQ_SEG_WR, pack_req(1, 2, 1, 0));
      send_item(REQ_SEG_WR, pack_req(1, 2, 0, 0));
      send_item(REQ_CLEAR, pack_req(0, 0, 0, 0));
      send_item(REQ_ALL_ON, pack_req(0, 0, 0, 0));
      send_item(REQ_UNUSED_LO, pack_req(31, 63, 1, 63));
      send_item(REQ_UNUSED_HI, pack_req(31, 63, 1, 63));
      send_item(REQ_TICK, pack_req(0, 0, 0, 0));
      send_item(REQ_TICK, pack_req(31, 63, 1, 63));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_results_done();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            0: write_config(1, 1, 1, 17, 64);
            1: write_config(8, 16, 1, 17, 64);
            2: write_config(4, 10, 3, 11, 20);
            3: write_config(0, 0, 0, 0, 0);
            4: write_config(15, 31, 2, 31, 127);
            5: write_config(8, 16, 65535, 1, 1);
            default: write_config($urandom_range(8, 1), $urandom_range(16, 1),
                                  $urandom_range(5, 1), $urandom_range(17, 1),
                                  $urandom_range(64, 1));
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_results_done();
            send_random();
         end
      end

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
